@@ src/qtsc_pkg.sv @@
// Shared token codes, error codes and character/token class functions for the query checker.
package qtsc_pkg;

	typedef logic [4:0] tok_t;
	typedef logic [3:0] err_t;

	localparam tok_t K_OPEN   = 5'd0;
	localparam tok_t K_CLOSE  = 5'd1;
	localparam tok_t K_AND    = 5'd2;
	localparam tok_t K_OR     = 5'd3;
	localparam tok_t K_NOT    = 5'd4;
	localparam tok_t K_VAR    = 5'd5;
	localparam tok_t K_CMP_LO = 5'd6;
	localparam tok_t K_CMP_HI = 5'd11;
	localparam tok_t K_MATCH  = 5'd12;
	localparam tok_t K_NOMATCH = 5'd13;
	localparam tok_t K_COMMA  = 5'd14;
	localparam tok_t K_VAL_LO = 5'd16;
	localparam tok_t K_VAL_HI = 5'd20;
	localparam tok_t K_REGEXP = 5'd21;
	localparam tok_t K_OTHER  = 5'd22;
	localparam tok_t K_NONE   = 5'd31;

	localparam err_t E_OK         = 4'd0;
	localparam err_t E_START      = 4'd1;
	localparam err_t E_AFT_OPEN   = 4'd2;
	localparam err_t E_AFT_CLOSE  = 4'd3;
	localparam err_t E_AFT_AND    = 4'd4;
	localparam err_t E_AFT_OR     = 4'd5;
	localparam err_t E_AFT_NOT    = 4'd6;
	localparam err_t E_AFT_NEGVAR = 4'd7;
	localparam err_t E_AFT_CMP    = 4'd8;
	localparam err_t E_AFT_MATCH  = 4'd9;
	localparam err_t E_AFT_COMMA  = 4'd10;
	localparam err_t E_AFT_REGEXP = 4'd11;
	localparam err_t E_NAME_CHAR  = 4'd12;
	localparam err_t E_EXCESS_OPEN  = 4'd13;
	localparam err_t E_EXCESS_CLOSE = 4'd14;
	localparam err_t E_ENDS_OPEN  = 4'd15;

	function automatic logic is_starter(input tok_t k);
		return (k == K_OPEN) || (k == K_VAR) || (k == K_NOT);
	endfunction

	function automatic logic is_joiner(input tok_t k);
		return (k == K_CLOSE) || (k == K_AND) || (k == K_OR);
	endfunction

	function automatic logic is_value(input tok_t k);
		return (k >= K_VAL_LO) && (k <= K_VAL_HI);
	endfunction

	function automatic logic name_char_ok(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39))     // 0-9
			|| ((c >= 8'h61) && (c <= 8'h7a))     // a-z
			|| ((c >= 8'h41) && (c <= 8'h5a))     // A-Z
			|| (c == 8'h5b) || (c == 8'h5d)       // [ ]
			|| (c == 8'h5f) || (c == 8'h2e)       // _ .
			|| (c == 8'h3a) || (c == 8'h5c);      // : backslash
	endfunction

endpackage

@@ src/query_token_syntax_checker_top.sv @@
// Top level of the query token syntax checker: state, depth counter and result register.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_ready, item_kind, token_kind,        | in
//          | name_char, end_of_query                           |
//  out     | out_valid, out_ready, error_code, query_done      | out
//
// Every input beat yields exactly one output beat, in the cycle after it is accepted.
// One beat per cycle sustained: the checks, depth update and verdict are a
// single combinational pass from the input port into the result register.
// in_ready is high whenever the result register is empty or being drained,
// so a stalled consumer holds the input off only while a result waits.
// arst_n clears query state (prev tokens = none, depth 0, no error) and the
// result valid flag; a beat with end_of_query also clears query state.
module query_token_syntax_checker_top #(
	parameter int NEST_DEPTH_MAX = 127
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 item_kind,
	input  qtsc_pkg::tok_t       token_kind,
	input  logic [7:0]           name_char,
	input  logic                 end_of_query,
	output logic                 out_valid,
	input  logic                 out_ready,
	output qtsc_pkg::err_t       error_code,
	output logic                 query_done
);
	import qtsc_pkg::*;

	// signed depth wide enough for +/-NEST_DEPTH_MAX
	localparam int DW = $clog2(NEST_DEPTH_MAX + 1) + 1;
	localparam logic signed [DW-1:0] DMAX = DW'(NEST_DEPTH_MAX);
	localparam logic signed [DW-1:0] DMIN = -DMAX;

	// query state
	tok_t                   prev_q, prev2_q;
	logic signed [DW-1:0]   depth_q;
	err_t                   lat_q;
	logic                   first_q;
	logic                   nerr_q;   // latched error came from current var name

	// result register
	logic  out_valid_q;
	err_t  error_code_q;
	logic  query_done_q;

	tok_t                   tok_c;
	err_t                   succ_code;
	tok_t                   prev_n, prev2_n;
	logic signed [DW-1:0]   depth_n;
	err_t                   lat_n;
	logic                   first_n;
	logic                   nerr_n;
	err_t                   code_n;
	logic                   accept;

	// kinds above "other" fold into "other"
	assign tok_c = (token_kind > K_OTHER) ? K_OTHER : token_kind;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	qtsc_succ u_succ (
		.tok   (tok_c),
		.prev  (prev_q),
		.prev2 (prev2_q),
		.first (first_q),
		.code  (succ_code)
	);

	always_comb begin
		prev_n  = prev_q;
		prev2_n = prev2_q;
		depth_n = depth_q;
		lat_n   = lat_q;
		first_n = first_q;
		nerr_n  = nerr_q;

		if (!item_kind) begin
			// first error wins; E_AFT_NEGVAR overrides a bad char in the negated var's name
			if (succ_code != E_OK) begin
				if (lat_q == E_OK)
					lat_n = succ_code;
				else if (nerr_q && succ_code == E_AFT_NEGVAR)
					lat_n = succ_code;
			end
			first_n = 1'b0;
			if (tok_c == K_OPEN) begin
				if (depth_q >= DMAX) begin
					if (lat_n == E_OK) lat_n = E_EXCESS_OPEN;
				end else begin
					depth_n = depth_q + DW'(1);
				end
			end else if (tok_c == K_CLOSE) begin
				if (depth_q <= DMIN) begin
					if (lat_n == E_OK) lat_n = E_EXCESS_CLOSE;
				end else begin
					depth_n = depth_q - DW'(1);
				end
			end
			prev2_n = prev_q;
			prev_n  = tok_c;
			nerr_n  = 1'b0;
		end else begin
			// name chars count only right after a variable token
			if (prev_q == K_VAR && !name_char_ok(name_char) && lat_q == E_OK) begin
				lat_n  = E_NAME_CHAR;
				nerr_n = 1'b1;
			end
		end

		// end-of-query verdict; nesting errors outrank a bad name char
		code_n = lat_n;
		if (end_of_query && (lat_n == E_OK || nerr_n)) begin
			if (prev_n == K_NONE)
				code_n = E_START;
			else if (prev_n == K_OPEN)
				code_n = E_ENDS_OPEN;
			else if (depth_n > DW'(0))
				code_n = E_EXCESS_OPEN;
			else if (depth_n < DW'(0))
				code_n = E_EXCESS_CLOSE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= K_NONE;
			prev2_q <= K_NONE;
			depth_q <= '0;
			lat_q   <= E_OK;
			first_q <= 1'b1;
			nerr_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_query) begin
				prev_q  <= K_NONE;
				prev2_q <= K_NONE;
				depth_q <= '0;
				lat_q   <= E_OK;
				first_q <= 1'b1;
				nerr_q  <= 1'b0;
			end else begin
				prev_q  <= prev_n;
				prev2_q <= prev2_n;
				depth_q <= depth_n;
				lat_q   <= lat_n;
				first_q <= first_n;
				nerr_q  <= nerr_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			error_code_q <= code_n;
			query_done_q <= end_of_query;
		end
	end

	assign out_valid  = out_valid_q;
	assign error_code = error_code_q;
	assign query_done = query_done_q;

endmodule

@@ src/qtsc_succ.sv @@
// Start-token and successor rule check for one query token.
module qtsc_succ (
	input  qtsc_pkg::tok_t tok,
	input  qtsc_pkg::tok_t prev,
	input  qtsc_pkg::tok_t prev2,
	input  logic           first,
	output qtsc_pkg::err_t code
);
	import qtsc_pkg::*;

	always_comb begin
		code = E_OK;
		if (first) begin
			if (!is_starter(tok))
				code = E_START;
		end else if (prev2 == K_NOT && prev == K_VAR) begin
			// negated variable must be followed by a joiner
			if (!is_joiner(tok))
				code = E_AFT_NEGVAR;
		end else if (prev == K_OPEN) begin
			if (!is_starter(tok)) code = E_AFT_OPEN;
		end else if (prev == K_CLOSE) begin
			if (!is_joiner(tok)) code = E_AFT_CLOSE;
		end else if (prev == K_AND) begin
			if (!is_starter(tok)) code = E_AFT_AND;
		end else if (prev == K_OR) begin
			if (!is_starter(tok)) code = E_AFT_OR;
		end else if (prev == K_NOT) begin
			if (tok != K_VAR) code = E_AFT_NOT;
		end else if (prev >= K_CMP_LO && prev <= K_CMP_HI) begin
			if (!is_value(tok)) code = E_AFT_CMP;
		end else if (prev == K_MATCH || prev == K_NOMATCH) begin
			if (tok != K_REGEXP) code = E_AFT_MATCH;
		end else if (prev == K_COMMA) begin
			if (!is_value(tok)) code = E_AFT_COMMA;
		end else if (prev == K_REGEXP) begin
			if (!is_joiner(tok)) code = E_AFT_REGEXP;
		end
	end

endmodule
